// ===== rtl/mhpq_pkg.sv =====
// shared types and constants for the min-heap priority queue
package mhpq_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int KEY_WIDTH_DEF = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		OP_INS,
		OP_FETCH,
		OP_SIFT
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} tok_ctl_t;

	typedef struct packed {
		logic hit;
		logic done;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_FETCH,
		S_SIFT
	} state_t;

endpackage

// ===== rtl/mhpq_cell.sv =====
// one heap level: its slice of the key store and the compare step for that level
module mhpq_cell import mhpq_pkg::*; #(
	parameter int LEVEL     = 0,
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int IDX_W     = $clog2(CAPACITY + 1),
	parameter int LVL_W     = $clog2($clog2(CAPACITY + 1))
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tok_ctl_t             prev_ctl,
	input  logic [KEY_WIDTH-1:0] prev_key,
	input  logic [IDX_W-1:0]     prev_idx,
	input  logic [LVL_W-1:0]     prev_lvl,
	input  logic [IDX_W-1:0]     prev_cnt,
	output tok_ctl_t             next_ctl,
	output logic [KEY_WIDTH-1:0] next_key,
	output logic [IDX_W-1:0]     next_idx,
	output logic [LVL_W-1:0]     next_lvl,
	output logic [IDX_W-1:0]     next_cnt,
	input  logic                 wb_en,
	input  logic [IDX_W-1:0]     wb_addr,
	input  logic [KEY_WIDTH-1:0] wb_key,
	output logic                 pwb_en,
	output logic [IDX_W-1:0]     pwb_addr,
	output logic [KEY_WIDTH-1:0] pwb_key,
	output rsp_t                 rsp,
	output logic [KEY_WIDTH-1:0] rsp_key
);

	localparam int LFULL  = 2 ** LEVEL;
	localparam int LDEPTH = (LFULL < (CAPACITY - LFULL + 1)) ? LFULL : (CAPACITY - LFULL + 1);
	localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
	localparam int MDEPTH = 2 ** LAW;
	localparam int GW     = IDX_W + 3;
	localparam logic [IDX_W-1:0] LMASK = IDX_W'(LFULL - 1);
	localparam logic [GW-1:0]    BASE  = GW'(LFULL - 1);
	localparam logic [LVL_W-1:0] MYLVL = LVL_W'(LEVEL);

	logic [KEY_WIDTH-1:0] mem [MDEPTH];

	// read addresses from the incoming word
	logic [LVL_W-1:0] sh;
	logic [IDX_W-1:0] path_loc;
	logic [IDX_W:0]   kid0;
	logic [LAW-1:0]   ra0, ra1;

	tok_ctl_t             ctl_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [LVL_W-1:0]     lvl_s1;
	logic [IDX_W-1:0]     cnt_s1;
	logic [LAW-1:0]       wa_s1;
	logic [KEY_WIDTH-1:0] rd0_q, rd1_q;

	// decision
	logic [GW-1:0]        g0, gsel, gkid;
	logic                 v0, v1, pick, more;
	logic [KEY_WIDTH-1:0] cval;
	logic [IDX_W-1:0]     cloc;

	tok_ctl_t             nctl_d;
	logic [KEY_WIDTH-1:0] nkey_d;
	logic [IDX_W-1:0]     nidx_d;
	logic                 own_we;
	logic [LAW-1:0]       own_wa;
	logic [KEY_WIDTH-1:0] own_wd;
	logic                 pwb_en_d;
	logic [KEY_WIDTH-1:0] pwb_key_d;
	rsp_t                 rsp_d;

	tok_ctl_t             next_ctl_q;
	logic [KEY_WIDTH-1:0] next_key_q;
	logic [IDX_W-1:0]     next_idx_q;
	logic [LVL_W-1:0]     next_lvl_q;
	logic [IDX_W-1:0]     next_cnt_q;
	logic                 pwb_en_q;
	logic [IDX_W-1:0]     pwb_addr_q;
	logic [KEY_WIDTH-1:0] pwb_key_q;
	rsp_t                 rsp_q;
	logic [KEY_WIDTH-1:0] rsp_key_q;

	always_comb begin
		sh       = prev_lvl - MYLVL;
		path_loc = (prev_idx >> sh) & LMASK;
		kid0     = {prev_idx, 1'b0};
		if (prev_ctl.op == OP_SIFT) begin
			ra0 = LAW'(kid0);
			ra1 = LAW'(kid0 | (IDX_W + 1)'(1));
		end else begin
			ra0 = LAW'(path_loc);
			ra1 = LAW'(path_loc);
		end
	end

	always_comb begin
		g0   = BASE + (GW'(idx_s1) << 1);
		v0   = g0 < GW'(cnt_s1);
		v1   = (g0 + GW'(1)) < GW'(cnt_s1);
		pick = v1 && (rd0_q > rd1_q);
		cval = pick ? rd1_q : rd0_q;
		gsel = g0 + GW'(pick);
		gkid = (gsel << 1) + GW'(1);
		more = gkid < GW'(cnt_s1);
		cloc = {idx_s1[IDX_W-2:0], pick};

		nctl_d    = '{valid: 1'b0, op: ctl_s1.op};
		nkey_d    = key_s1;
		nidx_d    = idx_s1;
		own_we    = 1'b0;
		own_wa    = wa_s1;
		own_wd    = key_s1;
		pwb_en_d  = 1'b0;
		pwb_key_d = key_s1;
		rsp_d     = '0;

		if (ctl_s1.valid) begin
			case (ctl_s1.op)
				OP_INS: begin
					if (lvl_s1 == MYLVL) begin
						own_we     = 1'b1;
						rsp_d.done = 1'b1;
					end else begin
						nctl_d.valid = 1'b1;
						// key settles here, the displaced one travels on
						if (rd0_q > key_s1) begin
							own_we = 1'b1;
							nkey_d = rd0_q;
						end
					end
				end
				OP_FETCH: begin
					if (lvl_s1 == MYLVL) begin
						rsp_d.hit = 1'b1;
					end else begin
						nctl_d.valid = 1'b1;
						// the root cell also reports the minimum on the way past
						if (LEVEL == 0) begin
							rsp_d.hit = 1'b1;
						end
					end
				end
				OP_SIFT: begin
					if (LEVEL == 0) begin
						nctl_d.valid = 1'b1;
					end else if (v0 && (key_s1 > cval)) begin
						pwb_en_d  = 1'b1;
						pwb_key_d = cval;
						if (more) begin
							nctl_d.valid = 1'b1;
							nidx_d       = cloc;
						end else begin
							own_we     = 1'b1;
							own_wa     = LAW'(cloc);
							rsp_d.done = 1'b1;
						end
					end else begin
						pwb_en_d   = 1'b1;
						rsp_d.done = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1     <= '0;
			next_ctl_q <= '0;
			pwb_en_q   <= 1'b0;
			rsp_q      <= '0;
		end else begin
			ctl_s1     <= prev_ctl;
			next_ctl_q <= nctl_d;
			pwb_en_q   <= pwb_en_d;
			rsp_q      <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		key_s1     <= prev_key;
		idx_s1     <= prev_idx;
		lvl_s1     <= prev_lvl;
		cnt_s1     <= prev_cnt;
		wa_s1      <= ra0;
		rd0_q      <= mem[ra0];
		rd1_q      <= mem[ra1];
		next_key_q <= nkey_d;
		next_idx_q <= nidx_d;
		next_lvl_q <= lvl_s1;
		next_cnt_q <= cnt_s1;
		pwb_addr_q <= idx_s1;
		pwb_key_q  <= pwb_key_d;
		rsp_key_q  <= rd0_q;
		if (wb_en) begin
			mem[LAW'(wb_addr)] <= wb_key;
		end else if (own_we) begin
			mem[own_wa] <= own_wd;
		end
	end

	assign next_ctl = next_ctl_q;
	assign next_key = next_key_q;
	assign next_idx = next_idx_q;
	assign next_lvl = next_lvl_q;
	assign next_cnt = next_cnt_q;
	assign pwb_en   = pwb_en_q;
	assign pwb_addr = pwb_addr_q;
	assign pwb_key  = pwb_key_q;
	assign rsp      = rsp_q;
	assign rsp_key  = rsp_key_q;

endmodule

// ===== rtl/min_heap_priority_queue.sv =====
// min-heap priority queue top level: command control and the chain of level cells
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+-----------------------------------
//   command  | cmd, key                   | taken when start is high, busy low
//   result   | status, min_key, count     | done high for one cycle, no stall
//
// each heap level is one cell; in each cell a word first reads memory, then compares
// and writes. an insert runs down to the level where its new entry lands, and a remove
// first fetches the root and the last entry, then sinks the last entry from the root.
// full and empty answers come in the cycle after the command is taken.
// reset clears the count and the control state only; the key store is never
// cleared and needs no pass.
// busy falls as done rises; the result receiver has no way to hold off a word.
module min_heap_priority_queue import mhpq_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] key,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] min_key,
	output logic [10:0] count
);

	localparam int NLVL  = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int LVL_W = $clog2(NLVL);

	function automatic logic [LVL_W-1:0] msb_pos(input logic [IDX_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int i = 0; i < IDX_W; i++) begin
			if (v[i]) begin
				r = LVL_W'(i);
			end
		end
		return r;
	endfunction

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     count_q, count_d;
	logic [KEY_WIDTH-1:0] root_q, root_d;
	logic                 hits_q, hits_d;
	logic [LVL_W-1:0]     lvl_q, lvl_d;

	tok_ctl_t             tok_ctl_q, tok_ctl_d;
	logic [KEY_WIDTH-1:0] tok_key_q, tok_key_d;
	logic [IDX_W-1:0]     tok_idx_q, tok_idx_d;
	logic [LVL_W-1:0]     tok_lvl_q, tok_lvl_d;
	logic [IDX_W-1:0]     tok_cnt_q, tok_cnt_d;

	logic                 done_q, done_d;
	status_t              status_q, status_d;
	logic [KEY_WIDTH-1:0] min_key_q, min_key_d;

	logic [KEY_WIDTH-1:0] key_w;
	logic [IDX_W-1:0]     count_inc;
	logic [LVL_W-1:0]     lvl_ins, lvl_last;

	// chain wiring, element i feeds cell i
	tok_ctl_t             c_ctl [NLVL+1];
	logic [KEY_WIDTH-1:0] c_key [NLVL+1];
	logic [IDX_W-1:0]     c_idx [NLVL+1];
	logic [LVL_W-1:0]     c_lvl [NLVL+1];
	logic [IDX_W-1:0]     c_cnt [NLVL+1];
	logic                 p_en  [NLVL];
	logic [IDX_W-1:0]     p_addr[NLVL];
	logic [KEY_WIDTH-1:0] p_key [NLVL];
	rsp_t                 r_ctl [NLVL];
	logic [KEY_WIDTH-1:0] r_key [NLVL];

	rsp_t                 rsp_any;
	logic [KEY_WIDTH-1:0] rsp_key_any;

	assign c_ctl[0] = tok_ctl_q;
	assign c_key[0] = tok_key_q;
	assign c_idx[0] = tok_idx_q;
	assign c_lvl[0] = tok_lvl_q;
	assign c_cnt[0] = tok_cnt_q;

	for (genvar i = 0; i < NLVL; i++) begin : g_lvl
		if (i == NLVL - 1) begin : g_last
			mhpq_cell #(
				.LEVEL    (i),
				.CAPACITY (CAPACITY),
				.KEY_WIDTH(KEY_WIDTH),
				.IDX_W    (IDX_W),
				.LVL_W    (LVL_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.prev_ctl(c_ctl[i]),
				.prev_key(c_key[i]),
				.prev_idx(c_idx[i]),
				.prev_lvl(c_lvl[i]),
				.prev_cnt(c_cnt[i]),
				.next_ctl(c_ctl[i+1]),
				.next_key(c_key[i+1]),
				.next_idx(c_idx[i+1]),
				.next_lvl(c_lvl[i+1]),
				.next_cnt(c_cnt[i+1]),
				.wb_en   (1'b0),
				.wb_addr ('0),
				.wb_key  ('0),
				.pwb_en  (p_en[i]),
				.pwb_addr(p_addr[i]),
				.pwb_key (p_key[i]),
				.rsp     (r_ctl[i]),
				.rsp_key (r_key[i])
			);
		end else begin : g_mid
			mhpq_cell #(
				.LEVEL    (i),
				.CAPACITY (CAPACITY),
				.KEY_WIDTH(KEY_WIDTH),
				.IDX_W    (IDX_W),
				.LVL_W    (LVL_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.prev_ctl(c_ctl[i]),
				.prev_key(c_key[i]),
				.prev_idx(c_idx[i]),
				.prev_lvl(c_lvl[i]),
				.prev_cnt(c_cnt[i]),
				.next_ctl(c_ctl[i+1]),
				.next_key(c_key[i+1]),
				.next_idx(c_idx[i+1]),
				.next_lvl(c_lvl[i+1]),
				.next_cnt(c_cnt[i+1]),
				.wb_en   (p_en[i+1]),
				.wb_addr (p_addr[i+1]),
				.wb_key  (p_key[i+1]),
				.pwb_en  (p_en[i]),
				.pwb_addr(p_addr[i]),
				.pwb_key (p_key[i]),
				.rsp     (r_ctl[i]),
				.rsp_key (r_key[i])
			);
		end
	end

	// at most one cell answers in a cycle
	always_comb begin
		rsp_any     = '0;
		rsp_key_any = r_key[0];
		for (int i = 0; i < NLVL; i++) begin
			rsp_any.hit  = rsp_any.hit | r_ctl[i].hit;
			rsp_any.done = rsp_any.done | r_ctl[i].done;
			if (r_ctl[i].hit) begin
				rsp_key_any = r_key[i];
			end
		end
	end

	always_comb begin
		key_w     = KEY_WIDTH'(key);
		count_inc = count_q + IDX_W'(1);
		lvl_ins   = msb_pos(count_inc);
		lvl_last  = msb_pos(count_q);

		state_d   = state_q;
		count_d   = count_q;
		root_d    = root_q;
		hits_d    = hits_q;
		lvl_d     = lvl_q;
		tok_ctl_d = '{valid: 1'b0, op: OP_INS};
		tok_key_d = tok_key_q;
		tok_idx_d = tok_idx_q;
		tok_lvl_d = tok_lvl_q;
		tok_cnt_d = tok_cnt_q;
		done_d    = 1'b0;
		status_d  = status_q;
		min_key_d = min_key_q;
		busy      = (state_q != S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd == CMD_INSERT) begin
						if (count_q >= IDX_W'(CAPACITY)) begin
							done_d    = 1'b1;
							status_d  = ST_FULL;
							min_key_d = '0;
						end else begin
							tok_ctl_d = '{valid: 1'b1, op: OP_INS};
							tok_key_d = key_w;
							tok_idx_d = count_inc;
							tok_lvl_d = lvl_ins;
							state_d   = S_INS;
						end
					end else begin
						if (count_q == '0) begin
							done_d    = 1'b1;
							status_d  = ST_EMPTY;
							min_key_d = '0;
						end else begin
							// fetch root and last entry in one pass down the path
							tok_ctl_d = '{valid: 1'b1, op: OP_FETCH};
							tok_idx_d = count_q;
							tok_lvl_d = lvl_last;
							lvl_d     = lvl_last;
							hits_d    = 1'b0;
							state_d   = S_FETCH;
						end
					end
				end
			end
			S_INS: begin
				if (rsp_any.done) begin
					count_d   = count_inc;
					done_d    = 1'b1;
					status_d  = ST_OK;
					min_key_d = '0;
					state_d   = S_IDLE;
				end
			end
			S_FETCH: begin
				if (rsp_any.hit) begin
					if (!hits_q) begin
						root_d = rsp_key_any;
						hits_d = 1'b1;
						if (lvl_q == '0) begin
							count_d   = '0;
							done_d    = 1'b1;
							status_d  = ST_OK;
							min_key_d = rsp_key_any;
							state_d   = S_IDLE;
						end
					end else begin
						// last entry goes to the root and sinks
						tok_ctl_d = '{valid: 1'b1, op: OP_SIFT};
						tok_key_d = rsp_key_any;
						tok_idx_d = '0;
						tok_cnt_d = count_q - IDX_W'(1);
						state_d   = S_SIFT;
					end
				end
			end
			S_SIFT: begin
				if (rsp_any.done) begin
					count_d   = count_q - IDX_W'(1);
					done_d    = 1'b1;
					status_d  = ST_OK;
					min_key_d = root_q;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			hits_q    <= 1'b0;
			tok_ctl_q <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			hits_q    <= hits_d;
			tok_ctl_q <= tok_ctl_d;
			done_q    <= done_d;
			status_q  <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		root_q    <= root_d;
		lvl_q     <= lvl_d;
		tok_key_q <= tok_key_d;
		tok_idx_q <= tok_idx_d;
		tok_lvl_q <= tok_lvl_d;
		tok_cnt_q <= tok_cnt_d;
		min_key_q <= min_key_d;
	end

	assign done    = done_q;
	assign status  = status_q;
	assign min_key = 32'(min_key_q);
	assign count   = 11'(count_q);

endmodule

// ===== tb/min_heap_priority_queue_tb.sv =====
// self-checking testbench for the min-heap priority queue, with its own heap predictor
`timescale 1ns / 1ps

module min_heap_priority_queue_tb import mhpq_pkg::*;;

	localparam int HEAP_DEPTH = CAPACITY_DEF;

	typedef struct packed {
		logic        op;
		logic [31:0] k;
	} heap_cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] min_key;
		logic [10:0] count;
	} heap_answer_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic        cmd    = CMD_INSERT;
	logic [31:0] key    = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [31:0] min_key;
	logic [10:0] count;

	heap_cmd_t    pending_words[$];
	heap_answer_t answers_due[$];
	int unsigned  mismatches = 0;
	int unsigned  gen_fill   = 0;
	logic         cmd_taken  = 1'b0;
	int unsigned  idle_left  = 0;
	bit           steady_run = 1'b0;

	// shadow heap, same layout as the block: children of i at 2i+1 and 2i+2
	logic [31:0]  shadow_keys[HEAP_DEPTH];
	int unsigned  shadow_fill = 0;

	min_heap_priority_queue uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.key     (key),
		.done    (done),
		.status  (status),
		.min_key (min_key),
		.count   (count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic heap_answer_t apply_heap_cmd(input logic op, input logic [31:0] k);
		heap_answer_t ans;
		int unsigned  pos;
		int unsigned  parent;
		int unsigned  child;
		logic [31:0]  moving;
		bit           settled;
		ans = '{status: ST_OK, min_key: '0, count: '0};
		if (op == CMD_INSERT) begin
			if (shadow_fill >= HEAP_DEPTH) begin
				ans.status = ST_FULL;
			end else begin
				pos = shadow_fill;
				settled = 1'b0;
				while (!settled && pos > 0) begin
					parent = (pos - 1) / 2;
					// equal parent stops the climb
					if (shadow_keys[parent] <= k) begin
						settled = 1'b1;
					end else begin
						shadow_keys[pos] = shadow_keys[parent];
						pos = parent;
					end
				end
				shadow_keys[pos] = k;
				shadow_fill++;
			end
		end else if (shadow_fill == 0) begin
			ans.status = ST_EMPTY;
		end else begin
			ans.min_key = shadow_keys[0];
			shadow_fill--;
			moving = shadow_keys[shadow_fill];
			pos = 0;
			settled = 1'b0;
			while (!settled && 2 * pos + 1 < shadow_fill) begin
				child = 2 * pos + 1;
				// right child only when strictly smaller
				if (child + 1 < shadow_fill && shadow_keys[child] > shadow_keys[child + 1])
					child++;
				if (moving <= shadow_keys[child]) begin
					settled = 1'b1;
				end else begin
					shadow_keys[pos] = shadow_keys[child];
					pos = child;
				end
			end
			shadow_keys[pos] = moving;
		end
		ans.count = 11'(shadow_fill);
		return ans;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
			mismatches++;
		end
	endtask

	task automatic queue_cmd(input logic op, input logic [31:0] k);
		pending_words.push_back('{op: op, k: k});
		if (op == CMD_INSERT && gen_fill < HEAP_DEPTH)
			gen_fill++;
		else if (op == CMD_REMOVE && gen_fill > 0)
			gen_fill--;
	endtask

	// mostly full-range keys, with extremes and a narrow band for duplicates
	function automatic logic [31:0] rand_key();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0000_0000;
		else if (r == 1)
			return 32'hFFFF_FFFF;
		else if (r < 4)
			return 32'($urandom_range(0, 15));
		else
			return 32'($urandom);
	endfunction

	task automatic queue_mix(input int unsigned n_words, input int unsigned insert_pct);
		repeat (n_words) begin
			if ($urandom_range(0, 99) < insert_pct)
				queue_cmd(CMD_INSERT, rand_key());
			else
				queue_cmd(CMD_REMOVE, 32'($urandom));
		end
	endtask

	// driver: a word stays on the ports until the block takes it
	always @(negedge clk) begin
		heap_cmd_t next_word;
		int unsigned roll;
		if (arst_n) begin
			if (start && !cmd_taken) begin
				// still waiting for the block
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_words.size() > 0) begin
				next_word = pending_words.pop_front();
				start <= 1'b1;
				cmd <= next_word.op;
				key <= next_word.k;
				if ($urandom_range(0, 99) == 0)
					steady_run <= !steady_run;
				roll = $urandom_range(0, 99);
				if (steady_run || roll < 50)
					idle_left <= 0;
				else if (roll < 85)
					idle_left <= $urandom_range(1, 3);
				else if (roll < 97)
					idle_left <= $urandom_range(4, 10);
				else
					idle_left <= $urandom_range(20, 60);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check the finished word first, then predict the one taken at this edge
	always @(posedge clk) begin
		heap_answer_t want;
		cmd_taken <= arst_n && start && !busy;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got status %0d key %0h count %0d",
					$time, status, min_key, count);
				mismatches++;
			end else begin
				want = answers_due.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("min_key", want.min_key, min_key);
				check_field("count", 32'(want.count), 32'(count));
			end
		end
		if (arst_n && start && !busy)
			answers_due.push_back(apply_heap_cmd(cmd, key));
	end

	initial begin
		// removes from an empty heap, extremes, then equal keys
		queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
		queue_cmd(CMD_REMOVE, 32'h0000_0000);
		queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
		queue_cmd(CMD_INSERT, 32'h0000_0000);
		queue_cmd(CMD_INSERT, 32'h8000_0000);
		queue_cmd(CMD_INSERT, 32'd5);
		queue_cmd(CMD_INSERT, 32'd5);
		queue_cmd(CMD_INSERT, 32'd5);
		queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
		queue_cmd(CMD_INSERT, 32'd1);
		queue_cmd(CMD_INSERT, 32'h7FFF_FFFF);
		queue_cmd(CMD_INSERT, 32'd5);
		repeat (11) queue_cmd(CMD_REMOVE, 32'($urandom));

		queue_mix(300, 55);
		// fill to capacity, then knock on the full heap
		while (gen_fill < HEAP_DEPTH) begin
			if ($urandom_range(0, 99) < 95)
				queue_cmd(CMD_INSERT, rand_key());
			else
				queue_cmd(CMD_REMOVE, 32'($urandom));
		end
		repeat (12) begin
			if ($urandom_range(0, 3) == 0)
				queue_cmd(CMD_REMOVE, 32'($urandom));
			else
				queue_cmd(CMD_INSERT, rand_key());
		end
		queue_mix(420, 15);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() > 0 || start) @(posedge clk);
		while (answers_due.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("** min_heap_priority_queue: PASSED **");
		else
			$display("** min_heap_priority_queue: FAILED **");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("** min_heap_priority_queue: FAILED **");
		$finish;
	end

endmodule
